[src/rmc_pkg.sv]
// ----------------------------------------------------------------------------
// rmc_pkg - shared types and constants for the measurement cross-check
// Word layouts, group codes, debounce length and fixed DC injection limits.
// ----------------------------------------------------------------------------
package rmc_pkg;

	localparam int unsigned MEAS_W = 16;
	localparam int unsigned THR_W  = 15;
	localparam int unsigned CNT_W  = 8;
	localparam int unsigned DIFF_W = 17;
	localparam int unsigned NGRP   = 4;

	// debounce length, ticks beyond this count flip the flag
	localparam logic [CNT_W-1:0] FILTER_COUNT = 8'd250;

	localparam logic signed [MEAS_W:0] DCI_BIAS        = 17'sd1000;
	localparam logic [THR_W-1:0]       DCI_SET_LIMIT   = 15'd500;
	localparam logic [THR_W-1:0]       DCI_CLEAR_LIMIT = 15'd300;

	// group codes
	localparam logic [1:0] GRP_VOLT = 2'd0;
	localparam logic [1:0] GRP_FREQ = 2'd1;
	localparam logic [1:0] GRP_DCI  = 2'd2;
	localparam logic [1:0] GRP_LEAK = 2'd3;

	// register indexes
	localparam logic [1:0] REG_ENABLE    = 2'd0;
	localparam logic [1:0] REG_VOLT_THR  = 2'd1;
	localparam logic [1:0] REG_FREQ_THR  = 2'd2;
	localparam logic [1:0] REG_LEAK_THR  = 2'd3;

	typedef struct packed {
		logic [1:0]               group;
		logic signed [MEAS_W-1:0] local_a;
		logic signed [MEAS_W-1:0] remote_a;
		logic signed [MEAS_W-1:0] local_b;
		logic signed [MEAS_W-1:0] remote_b;
		logic signed [MEAS_W-1:0] local_c;
		logic signed [MEAS_W-1:0] remote_c;
		logic                     remote_adc_fault;
	} in_word_t;

	typedef struct packed {
		logic [1:0]      group_echo;
		logic            group_fault;
		logic [NGRP-1:0] fault_vector;
	} out_word_t;

	// per-tick verdict handed to the debounce state
	typedef struct packed {
		logic [1:0] group;
		logic       force_clear;
		logic       any_over;
		logic       all_under;
	} check_t;

endpackage

[src/redundant_measure_crosscheck_top.sv]
// ----------------------------------------------------------------------------
// redundant_measure_crosscheck_top - redundant sensor cross-check
// Compares local and remote measurements per group and debounces mismatch.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_word): one word per group tick,
//   carrying the group code, up to three local/remote pairs and the remote
//   ADC fault bit. Output channel (out_valid / out_stall / out_word): one
//   word per input word, with the group, its flag and all four flags.
//   Config port (cfg_wr_en / cfg_index / cfg_data): write while idle.
// Path: the accepting edge loads the input register; compare + debounce then
//   load the result register, which raises out_valid.
// Throughput: one word per cycle unless the output stalls; the debounce
//   state is updated in the same cycle the result register loads, so the
//   next word sees it at once.
// Reset: flags and counters clear, registers return to their defaults
//   (enable 15, thresholds 150 / 50 / 100), both stages empty.
// Stall: a held result keeps its word; the input register still takes one
//   more word, then in_stall rises until the result is taken.
// ----------------------------------------------------------------------------
module redundant_measure_crosscheck_top
	import rmc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  in_word_t         in_word,
	output logic             out_valid,
	input  logic             out_stall,
	output out_word_t        out_word,
	input  logic             cfg_wr_en,
	input  logic [1:0]       cfg_index,
	input  logic [THR_W-1:0] cfg_data
);

	// config registers
	logic [NGRP-1:0]  enable_q;
	logic [THR_W-1:0] volt_thr_q, freq_thr_q, leak_thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q   <= 4'd15;
			volt_thr_q <= 15'd150;
			freq_thr_q <= 15'd50;
			leak_thr_q <= 15'd100;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_ENABLE:   enable_q   <= cfg_data[NGRP-1:0];
				REG_VOLT_THR: volt_thr_q <= cfg_data;
				REG_FREQ_THR: freq_thr_q <= cfg_data;
				REG_LEAK_THR: leak_thr_q <= cfg_data;
				default:      ;
			endcase
		end
	end

	// stage 1: input register
	in_word_t word_s1;
	logic     valid_s1;
	logic     adv;     // stage 1 moves into the result register

	assign adv      = valid_s1 && (!out_valid || !out_stall);
	assign in_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			word_s1 <= in_word;
		end
	end

	// group decode: limits, bias, pair usage, remote ADC fault usage
	logic [THR_W-1:0] set_thr, clr_thr;
	logic             bias_en, three_pair, adc_used;

	always_comb begin
		unique case (word_s1.group)
			GRP_VOLT: begin
				set_thr = volt_thr_q;  clr_thr = volt_thr_q;
				bias_en = 1'b0; three_pair = 1'b1; adc_used = 1'b1;
			end
			GRP_FREQ: begin
				set_thr = freq_thr_q;  clr_thr = freq_thr_q;
				bias_en = 1'b0; three_pair = 1'b0; adc_used = 1'b0;
			end
			GRP_DCI: begin
				set_thr = DCI_SET_LIMIT; clr_thr = DCI_CLEAR_LIMIT;
				bias_en = 1'b1; three_pair = 1'b1; adc_used = 1'b1;
			end
			default: begin
				set_thr = leak_thr_q;  clr_thr = leak_thr_q;
				bias_en = 1'b0; three_pair = 1'b0; adc_used = 1'b1;
			end
		endcase
	end

	logic over_a, under_a, over_b, under_b, over_c, under_c;

	rmc_diff u_diff_a (
		.local_val (word_s1.local_a), .remote_val (word_s1.remote_a),
		.bias_en   (bias_en), .set_thr (set_thr), .clr_thr (clr_thr),
		.over      (over_a), .under (under_a)
	);

	rmc_diff u_diff_b (
		.local_val (word_s1.local_b), .remote_val (word_s1.remote_b),
		.bias_en   (bias_en), .set_thr (set_thr), .clr_thr (clr_thr),
		.over      (over_b), .under (under_b)
	);

	rmc_diff u_diff_c (
		.local_val (word_s1.local_c), .remote_val (word_s1.remote_c),
		.bias_en   (bias_en), .set_thr (set_thr), .clr_thr (clr_thr),
		.over      (over_c), .under (under_c)
	);

	// combine pairs; single-value groups look only at pair a
	check_t chk;

	always_comb begin
		chk.group       = word_s1.group;
		chk.force_clear = !enable_q[word_s1.group] || (adc_used && word_s1.remote_adc_fault);
		chk.any_over    = over_a || (three_pair && (over_b || over_c));
		chk.all_under   = under_a && (!three_pair || (under_b && under_c));
	end

	logic [NGRP-1:0] flags_next;

	rmc_debounce u_debounce (
		.clk        (clk),
		.arst_n     (arst_n),
		.upd        (adv),
		.chk        (chk),
		.flags_next (flags_next)
	);

	// stage 2: result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_word.group_echo   <= word_s1.group;
			out_word.group_fault  <= flags_next[word_s1.group];
			out_word.fault_vector <= flags_next;
		end
	end

`ifndef SYNTHESIS
	// the per-group flag always agrees with its bit in the vector
	a_flag_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_word.group_fault == out_word.fault_vector[out_word.group_echo])
		else $error("group_fault disagrees with fault_vector");

	// a disabled group reports its flag low
	a_disabled_low: assert property (@(posedge clk) disable iff (!arst_n)
		adv && !enable_q[word_s1.group] |=> !out_word.group_fault)
		else $error("disabled group reported a fault");

	// input back-pressure only while a word is held in stage 1
	a_stall_held: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid && out_stall)
		else $error("input stalled without a blocked word");
`endif

endmodule

[src/rmc_diff.sv]
// ----------------------------------------------------------------------------
// rmc_diff - one local/remote pair compare
// Absolute difference with optional local bias, checked against both limits.
// ----------------------------------------------------------------------------
module rmc_diff
	import rmc_pkg::*;
(
	input  logic signed [MEAS_W-1:0] local_val,
	input  logic signed [MEAS_W-1:0] remote_val,
	input  logic                     bias_en,
	input  logic [THR_W-1:0]         set_thr,
	input  logic [THR_W-1:0]         clr_thr,
	output logic                     over,
	output logic                     under
);

	logic signed [MEAS_W:0]   loc_b;
	logic signed [MEAS_W+1:0] diff;
	logic [DIFF_W-1:0]        mag;

	always_comb begin
		loc_b = 17'(local_val);
		if (bias_en) begin
			loc_b = 17'(local_val) + DCI_BIAS;
		end
		diff = 18'(loc_b) - 18'(remote_val);
		mag  = diff[MEAS_W+1] ? DIFF_W'(-diff) : DIFF_W'(diff);
		over  = mag > DIFF_W'(set_thr);
		under = mag < DIFF_W'(clr_thr);
	end

endmodule

[src/rmc_debounce.sv]
// ----------------------------------------------------------------------------
// rmc_debounce - fault flags and set/clear filter counters
// Applies one tick's verdict to its group and offers the updated flags.
// ----------------------------------------------------------------------------
module rmc_debounce
	import rmc_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            upd,
	input  check_t          chk,
	output logic [NGRP-1:0] flags_next
);

	logic [NGRP-1:0]  fault_q;
	logic [CNT_W-1:0] set_cnt_q [NGRP];
	logic [CNT_W-1:0] clr_cnt_q [NGRP];
	logic [CNT_W-1:0] set_cur, clr_cur, set_inc, clr_inc, set_next, clr_next;

	always_comb begin
		set_cur    = set_cnt_q[chk.group];
		clr_cur    = clr_cnt_q[chk.group];
		set_inc    = set_cur + 1'b1;
		clr_inc    = clr_cur + 1'b1;
		flags_next = fault_q;
		set_next   = set_cur;
		clr_next   = clr_cur;
		if (chk.force_clear) begin
			flags_next[chk.group] = 1'b0;
		end else if (!fault_q[chk.group]) begin
			if (chk.any_over) begin
				if (set_inc > FILTER_COUNT) begin
					set_next              = '0;
					flags_next[chk.group] = 1'b1;
				end else begin
					set_next = set_inc;
				end
			end else begin
				set_next = '0;
			end
		end else begin
			set_next = '0;
			if (chk.all_under) begin
				if (clr_inc > FILTER_COUNT) begin
					clr_next              = '0;
					flags_next[chk.group] = 1'b0;
				end else begin
					clr_next = clr_inc;
				end
			end else begin
				clr_next = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fault_q <= '0;
			for (int i = 0; i < NGRP; i++) begin
				set_cnt_q[i] <= '0;
				clr_cnt_q[i] <= '0;
			end
		end else if (upd) begin
			fault_q              <= flags_next;
			set_cnt_q[chk.group] <= set_next;
			clr_cnt_q[chk.group] <= clr_next;
		end
	end

endmodule
